FILE: rtl/core/sfcd_pkg.sv
`timescale 1ns / 1ps

package sfcd_pkg;

    // Configuration register indexes
    localparam logic [7:0] CFG_HEADER_VALUE = 8'd0;
    localparam logic [7:0] CFG_RAW_OFFSET   = 8'd1;
    localparam logic [7:0] CFG_SCALE_GAIN   = 8'd2;
    localparam logic [7:0] CFG_OUTPUT_BASE  = 8'd3;

    localparam logic [7:0]  RST_HEADER_VALUE = 8'h0F;
    localparam logic [10:0] RST_RAW_OFFSET   = 11'd352;
    localparam logic [16:0] RST_SCALE_GAIN   = 17'd48759;
    localparam logic [15:0] RST_OUTPUT_BASE  = 16'd1000;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       frame_start;
    } t_in_item;

    typedef struct packed {
        logic [3:0]  channel_index;
        logic [10:0] raw_value;
        logic [15:0] scaled_value;
        logic        last_channel;
    } t_out_item;

    // Unpacked channel handed from the unpacker to the scaler
    typedef struct packed {
        logic [3:0]  channel_index;
        logic [10:0] raw_value;
        logic        last_channel;
    } t_chan;

    typedef struct packed {
        logic [10:0] raw_offset;
        logic [16:0] scale_gain;
        logic [15:0] output_base;
    } t_scale_cfg;

endpackage

FILE: rtl/core/sfcd_unpack.sv
`timescale 1ns / 1ps

module sfcd_unpack
    import sfcd_pkg::*;
#(
    parameter int CHANNEL_COUNT = 16,
    parameter int CHANNEL_BITS  = 11
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic       i_load,
    input  t_in_item   i_item,
    input  logic [7:0] i_header_value,
    output logic       o_valid,
    output t_chan      o_chan
);

    localparam int ACC_W  = CHANNEL_BITS + 7;
    localparam int HELD_W = $clog2(CHANNEL_BITS + 8);
    localparam int CH_W   = $clog2(CHANNEL_COUNT + 1);

    logic [ACC_W-1:0]  r_acc,  n_acc;
    logic [HELD_W-1:0] r_held, n_held;
    logic [CH_W-1:0]   r_chan, n_chan;
    logic              r_frame_ok, n_frame_ok;
    logic              r_valid, n_valid;
    t_chan             r_item, n_item;

    logic [ACC_W-1:0]  acc_ext;
    logic [HELD_W-1:0] held8;

    assign acc_ext = r_acc | (ACC_W'(i_item.rx_byte) << r_held);
    assign held8   = r_held + HELD_W'(8);

    always_comb begin
        n_acc      = r_acc;
        n_held     = r_held;
        n_chan     = r_chan;
        n_frame_ok = r_frame_ok;
        n_valid    = 1'b0;
        n_item.channel_index = 4'(r_chan);
        n_item.raw_value     = 11'(acc_ext[CHANNEL_BITS-1:0]);
        n_item.last_channel  = (r_chan == CH_W'(CHANNEL_COUNT - 1));
        if (i_accept) begin
            priority if (i_item.frame_start) begin
                // Marked byte is only a header check; restart the frame
                n_frame_ok = (i_item.rx_byte == i_header_value);
                n_acc      = '0;
                n_held     = '0;
                n_chan     = '0;
            end else if (r_frame_ok && (r_chan < CH_W'(CHANNEL_COUNT))) begin
                if (held8 >= HELD_W'(CHANNEL_BITS)) begin
                    n_acc   = acc_ext >> CHANNEL_BITS;
                    n_held  = held8 - HELD_W'(CHANNEL_BITS);
                    n_chan  = r_chan + CH_W'(1);
                    n_valid = 1'b1;
                end else begin
                    n_acc  = acc_ext;
                    n_held = held8;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc      <= '0;
            r_held     <= '0;
            r_chan     <= '0;
            r_frame_ok <= 1'b0;
            r_valid    <= 1'b0;
        end else begin
            r_acc      <= n_acc;
            r_held     <= n_held;
            r_chan     <= n_chan;
            r_frame_ok <= n_frame_ok;
            if (i_load) begin
                r_valid <= n_valid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_item <= n_item;
        end
    end

    assign o_valid = r_valid;
    assign o_chan  = r_item;

endmodule

FILE: rtl/core/sfcd_scale.sv
`timescale 1ns / 1ps

module sfcd_scale
    import sfcd_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  t_chan      i_chan,
    input  t_scale_cfg i_cfg,
    input  logic       i_out_stall,
    output logic       o_load,
    output logic       o_out_valid,
    output t_out_item  o_out_item
);

    logic signed [11:0] diff;
    logic signed [17:0] gain_s;
    logic signed [29:0] prod;
    logic signed [33:0] sum;
    logic [15:0]        scaled;
    logic               r_out_valid;
    t_out_item          r_out_item, n_out_item;

    assign diff   = $signed({1'b0, i_chan.raw_value}) - $signed({1'b0, i_cfg.raw_offset});
    assign gain_s = $signed({1'b0, i_cfg.scale_gain});
    assign prod   = diff * gain_s;
    assign sum    = $signed({2'b00, i_cfg.output_base, 16'h0000}) + 34'(prod);

    // Truncate the Q16 sum and clamp to 0..65535
    always_comb begin
        priority if (sum[33]) begin
            scaled = '0;
        end else if (sum[32]) begin
            scaled = 16'hFFFF;
        end else begin
            scaled = sum[31:16];
        end
    end

    always_comb begin
        n_out_item.channel_index = i_chan.channel_index;
        n_out_item.raw_value     = i_chan.raw_value;
        n_out_item.scaled_value  = scaled;
        n_out_item.last_channel  = i_chan.last_channel;
    end

    assign o_load = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_load) begin
            r_out_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_load && i_valid) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

endmodule

FILE: rtl/core/sbus_frame_channel_decoder_top.sv
`timescale 1ns / 1ps

// SBUS frame channel decoder.
// Input channel: one received byte per item (i_in_item), with frame_start set
// on the byte that follows a line idle gap. A frame whose first byte differs
// from the header register is ignored up to the next marked byte.
// Output channel: one item per completed channel: index, 11-bit raw value,
// scaled value base + (raw - offset) * gain / 2^16, clamped to 0..65535, and
// a last flag on the final channel. Flag and end bytes produce nothing.
// Pipeline: two register stages (unpack register, then scale/result register);
// o_out_valid is the result register's flag, loaded from the unpack register.
// Throughput: one byte per unstalled cycle; the scaler has one 12x18 multiply per cycle.
// Stall: the two registers form a pipeline; when i_out_stall holds the result
// the unpack register still fills, and o_in_stall rises only when both are
// occupied. A held result keeps its payload.
// Reset: clears decode state (no frame active) and loads register defaults
// header 0x0F, offset 352, gain 48759 (Q16), base 1000.
// Configuration: write index/data on i_cfg_*, always ready; write only while
// the decoder is idle.

module sbus_frame_channel_decoder_top
    import sfcd_pkg::*;
#(
    parameter int CHANNEL_COUNT = 16,
    parameter int CHANNEL_BITS  = 11
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in_item    i_in_item,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out_item   o_out_item,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [7:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    logic [7:0]  r_header_value;
    logic [10:0] r_raw_offset;
    logic [16:0] r_scale_gain;
    logic [15:0] r_output_base;
    t_scale_cfg  scale_cfg;

    logic  s1_valid;
    t_chan s1_chan;
    logic  s2_load;
    logic  s1_load;
    logic  in_accept;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_value <= RST_HEADER_VALUE;
            r_raw_offset   <= RST_RAW_OFFSET;
            r_scale_gain   <= RST_SCALE_GAIN;
            r_output_base  <= RST_OUTPUT_BASE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            // Unknown indexes are dropped
            unique case (i_cfg_index)
                CFG_HEADER_VALUE: r_header_value <= i_cfg_data[7:0];
                CFG_RAW_OFFSET:   r_raw_offset   <= i_cfg_data[10:0];
                CFG_SCALE_GAIN:   r_scale_gain   <= i_cfg_data[16:0];
                CFG_OUTPUT_BASE:  r_output_base  <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    assign scale_cfg.raw_offset  = r_raw_offset;
    assign scale_cfg.scale_gain  = r_scale_gain;
    assign scale_cfg.output_base = r_output_base;

    assign s1_load    = !s1_valid || s2_load;
    assign o_in_stall = !s1_load;
    assign in_accept  = i_in_valid && s1_load;

    sfcd_unpack #(
        .CHANNEL_COUNT (CHANNEL_COUNT),
        .CHANNEL_BITS  (CHANNEL_BITS)
    ) u_unpack (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_accept       (in_accept),
        .i_load         (s1_load),
        .i_item         (i_in_item),
        .i_header_value (r_header_value),
        .o_valid        (s1_valid),
        .o_chan         (s1_chan)
    );

    sfcd_scale u_scale (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_chan      (s1_chan),
        .i_cfg       (scale_cfg),
        .i_out_stall (i_out_stall),
        .o_load      (s2_load),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item)
    );

endmodule
